// ===== sv/mted_pkg.sv =====
// Shared constants, types and codes of the Manchester edge-timing decoder.
package mted_pkg;

  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned BitsPerWord = 8;
  localparam int unsigned DataWidth   = 8;
  localparam int unsigned CfgWidth    = 32;
  localparam int unsigned BitCntW     = (BitsPerWord > 1) ? $clog2(BitsPerWord) : 1;

  localparam logic [CfgWidth-1:0] ShortMinReset = CfgWidth'(10000);
  localparam logic [CfgWidth-1:0] ShortMaxReset = CfgWidth'(30000);

  typedef enum logic {
    CfgShortMin = 1'b0,
    CfgShortMax = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PhStart  = 3'd0,
    PhStart1 = 3'd1,
    PhMid1   = 3'd2,
    PhStart0 = 3'd3,
    PhMid0   = 3'd4
  } phase_e;

  // Classification of one edge, passed from the edge timer to the decoder.
  typedef struct packed {
    logic glitch;
    logic is_short;
    logic space;
  } edge_class_t;

endpackage

// ===== sv/mted_timer.sv =====
// Edge timer: keeps the last edge time and classifies the current interval.
module mted_timer import mted_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [TimeWidth-1:0] edge_time_i,
  input  logic                 level_i,
  input  logic [CfgWidth-1:0]  short_min_i,
  input  logic [CfgWidth-1:0]  short_max_i,
  output edge_class_t          cls_o
);

  logic [TimeWidth-1:0] last_edge_q;
  logic [TimeWidth-1:0] last_edge_d;
  logic [TimeWidth-1:0] interval;

  // The subtraction wraps with the free-running timestamp.
  assign interval = edge_time_i - last_edge_q;

  always_comb begin
    cls_o.glitch   = interval < TimeWidth'(short_min_i);
    cls_o.is_short = interval < TimeWidth'(short_max_i);
    cls_o.space    = level_i;
  end

  assign last_edge_d = step_i ? edge_time_i : last_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
    end else begin
      last_edge_q <= last_edge_d;
    end
  end

endmodule

// ===== sv/mted_fsm.sv =====
// Manchester phase machine and bit assembler that releases completed words.
module mted_fsm import mted_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  edge_class_t            cls_i,
  output logic                   word_valid_o,
  output logic [BitsPerWord-1:0] word_o
);

  phase_e                 phase_q, phase_d;
  logic [BitsPerWord-1:0] shift_q, shift_d;
  logic [BitCntW-1:0]     cnt_q, cnt_d;
  logic                   have_bit;
  logic                   bit_val;
  logic [BitsPerWord-1:0] shifted;

  always_comb begin
    phase_d  = phase_q;
    have_bit = 1'b0;
    bit_val  = 1'b0;
    case (phase_q)
      PhStart: begin
        have_bit = 1'b1;
        bit_val  = 1'b1;
        phase_d  = PhMid1;
      end
      PhStart1: begin
        if (cls_i.is_short && cls_i.space) begin
          have_bit = 1'b1;
          bit_val  = 1'b1;
          phase_d  = PhMid1;
        end
      end
      PhMid1: begin
        if (cls_i.is_short && !cls_i.space) begin
          phase_d = PhStart1;
        end else if (!cls_i.is_short && !cls_i.space) begin
          have_bit = 1'b1;
          phase_d  = PhMid0;
        end
      end
      PhStart0: begin
        if (cls_i.is_short && !cls_i.space) begin
          have_bit = 1'b1;
          phase_d  = PhMid0;
        end
      end
      PhMid0: begin
        if (cls_i.is_short && cls_i.space) begin
          phase_d = PhStart0;
        end else if (!cls_i.is_short && cls_i.space) begin
          have_bit = 1'b1;
          bit_val  = 1'b1;
          phase_d  = PhMid1;
        end
      end
      default: begin
        phase_d = PhStart;
      end
    endcase

    if (BitsPerWord > 1) begin
      shifted = {shift_q[BitsPerWord-2:0], bit_val};
    end else begin
      shifted = BitsPerWord'(bit_val);
    end

    word_valid_o = 1'b0;
    word_o       = shifted;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    if (!step_i || cls_i.glitch) begin
      // A glitch or an idle cycle leaves the decoder untouched.
      phase_d = phase_q;
    end else if (have_bit) begin
      if (cnt_q == BitCntW'(BitsPerWord - 1)) begin
        word_valid_o = 1'b1;
        shift_d      = '0;
        cnt_d        = '0;
      end else begin
        shift_d = shifted;
        cnt_d   = cnt_q + BitCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      shift_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end
  end

  a_word_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_o |=> (cnt_q == '0) && (shift_q == '0))
    else $error("bit assembler not cleared after a completed word");

  a_glitch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cls_i.glitch) |=> $stable(phase_q) && $stable(cnt_q))
    else $error("glitch edge changed the decoder state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BitCntW'(BitsPerWord - 1))
    else $error("bit count beyond word length");

endmodule

// ===== sv/manchester_edge_timing_decoder_unit.sv =====
// Top level of the Manchester edge-timing decoder: staging, config and result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | in_valid_i / in_ready_o   | edge_time_us_i[31:0], line_level_i
//   output   | out_valid_o / out_ready_i | data_byte_o[7:0]
//   config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i[31:0]
//
// An edge is taken into a staging register and decoded from there once the result
// register is free, where the interval compare and the phase machine update run in
// one pass; a completed byte is then written into the result register.
// One edge per cycle is sustained; the staging register stalls only while a byte
// waits in the result register and the result channel is not ready.
// Reset clears the last edge time, the decoder phase and the bit assembler and
// loads the default thresholds; no clearing pass is needed.
module manchester_edge_timing_decoder_unit import mted_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TimeWidth-1:0] edge_time_us_i,
  input  logic                 line_level_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataWidth-1:0] data_byte_o,
  input  logic                 cfg_we_i,
  input  cfg_reg_e             cfg_idx_i,
  input  logic [CfgWidth-1:0]  cfg_wdata_i
);

  logic                   stg_valid_q, stg_valid_d;
  logic [TimeWidth-1:0]   stg_time_q;
  logic                   stg_level_q;
  logic [CfgWidth-1:0]    short_min_q, short_max_q;
  logic                   out_valid_q, out_valid_d;
  logic [DataWidth-1:0]   data_q;
  logic                   out_free;
  logic                   proc;
  logic                   in_fire;
  edge_class_t            cls;
  logic                   word_valid;
  logic [BitsPerWord-1:0] word;

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = stg_valid_q && out_free;
  assign in_ready_o = !stg_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  mted_timer u_timer (
    .clk_i,
    .rst_ni,
    .step_i      (proc),
    .edge_time_i (stg_time_q),
    .level_i     (stg_level_q),
    .short_min_i (short_min_q),
    .short_max_i (short_max_q),
    .cls_o       (cls)
  );

  mted_fsm u_fsm (
    .clk_i,
    .rst_ni,
    .step_i       (proc),
    .cls_i        (cls),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_fire) begin
      stg_valid_d = 1'b1;
    end else if (proc) begin
      stg_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc && word_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      short_min_q <= ShortMinReset;
      short_max_q <= ShortMaxReset;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgShortMin: short_min_q <= cfg_wdata_i;
          CfgShortMax: short_max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_time_q  <= edge_time_us_i;
      stg_level_q <= line_level_i;
    end
    if (proc && word_valid) begin
      data_q <= DataWidth'(word);
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stg_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(proc && word_valid))
    else $error("result appeared without a completed word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && word_valid) |-> out_free)
    else $error("completed word would overwrite a pending result");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Manchester edge-timing decoder unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mted_pkg::*;

  localparam int CycleLimit      = 200000;
  localparam int HoldCycles      = 400;
  localparam int SettleCycles    = 4;
  localparam int ItemsPerSetting = 150;
  localparam int NumSettings     = 6;
  localparam int MaxPrinted      = 40;

  typedef enum logic {
    RowEdge,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    cfg_reg_e               idx;
    logic [TimeWidth-1:0]   value;
    logic                   lvl;
    logic                   has_exp;
    logic [DataWidth-1:0]   exp_byte;
  } stim_row_t;

  // Directed sequence from reset: boundary intervals, wrap, glitches and config extremes.
  localparam stim_row_t DirectedRows [25] = '{
    '{RowEdge, CfgShortMin, 32'd10000,     1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd19999,     1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd29999,     1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd59999,     1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd69999,     1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd99999,     1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd109999,    1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd119999,    1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd149999,    1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'h0000_0000, 1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'd40000,     1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'hFFFF_F000, 1'b0, 1'b1, 8'hCA},
    '{RowEdge, CfgShortMin, 32'h0000_2000, 1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'h0000_4710, 1'b1, 1'b0, 8'h00},
    '{RowCfg,  CfgShortMin, 32'd1,         1'b0, 1'b0, 8'h00},
    '{RowCfg,  CfgShortMax, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'h0000_4711, 1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'h0000_4711, 1'b1, 1'b0, 8'h00},
    '{RowCfg,  CfgShortMin, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00},
    '{RowCfg,  CfgShortMax, 32'd5,         1'b0, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'h0000_4710, 1'b1, 1'b0, 8'h00},
    '{RowEdge, CfgShortMin, 32'h0000_4715, 1'b0, 1'b0, 8'h00},
    '{RowCfg,  CfgShortMin, 32'd10000,     1'b0, 1'b0, 8'h00},
    '{RowCfg,  CfgShortMax, 32'd30000,     1'b0, 1'b0, 8'h00}
  };

  // Threshold pairs for the random part: reset values, extremes, and max not above min.
  localparam logic [31:0] SettingMin [NumSettings] = '{
    32'd10000, 32'd1, 32'd100, 32'h8000_0000, 32'd500, 32'd37
  };
  localparam logic [31:0] SettingMax [NumSettings] = '{
    32'd30000, 32'd2, 32'd300, 32'hFFFF_FFFF, 32'd200, 32'd120
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TimeWidth-1:0] edge_time = '0;
  logic                 line_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DataWidth-1:0] data_byte;
  logic                 cfg_we = 1'b0;
  cfg_reg_e             cfg_idx = CfgShortMin;
  logic [CfgWidth-1:0]  cfg_wdata = '0;

  // Decoder state as the testbench predicts it.
  logic [TimeWidth-1:0] prev_edge_us = '0;
  phase_e               phase = PhStart;
  logic [DataWidth-1:0] shift_acc = '0;
  int                   shift_cnt = 0;
  logic [CfgWidth-1:0]  thr_min = ShortMinReset;
  logic [CfgWidth-1:0]  thr_max = ShortMaxReset;

  logic [DataWidth-1:0] byte_q [$];
  logic [TimeWidth-1:0] now_us = '0;
  logic                 prev_bit = 1'b1;
  bit                   steady = 1'b0;
  bit                   hold_off_req = 1'b0;
  int                   mismatch_count = 0;
  int                   cycle_count = 0;

  manchester_edge_timing_decoder_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .edge_time_us_i(edge_time),
    .line_level_i  (line_level),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .data_byte_o   (data_byte),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Advances the decoder state by one edge; returns 1 when a byte completes.
  function automatic bit decode_edge(input logic [TimeWidth-1:0] t, input logic space,
                                     output logic [DataWidth-1:0] done_byte);
    logic [TimeWidth-1:0] interval;
    logic                 short_iv;
    logic                 have_bit;
    logic                 bit_val;
    interval     = t - prev_edge_us;
    prev_edge_us = t;
    done_byte    = '0;
    have_bit     = 1'b0;
    bit_val      = 1'b0;
    if (interval < thr_min) begin
      return 1'b0;
    end
    short_iv = interval < thr_max;
    case (phase)
      PhStart: begin
        have_bit = 1'b1;
        bit_val  = 1'b1;
        phase    = PhMid1;
      end
      PhStart1: begin
        if (short_iv && space) begin
          have_bit = 1'b1;
          bit_val  = 1'b1;
          phase    = PhMid1;
        end
      end
      PhMid1: begin
        if (!space && short_iv) begin
          phase = PhStart1;
        end else if (!space) begin
          have_bit = 1'b1;
          bit_val  = 1'b0;
          phase    = PhMid0;
        end
      end
      PhStart0: begin
        if (short_iv && !space) begin
          have_bit = 1'b1;
          bit_val  = 1'b0;
          phase    = PhMid0;
        end
      end
      PhMid0: begin
        if (space && short_iv) begin
          phase = PhStart0;
        end else if (space) begin
          have_bit = 1'b1;
          bit_val  = 1'b1;
          phase    = PhMid1;
        end
      end
      default: begin
        phase = PhStart;
      end
    endcase
    if (!have_bit) begin
      return 1'b0;
    end
    shift_acc = {shift_acc[DataWidth-2:0], bit_val};
    shift_cnt++;
    if (shift_cnt >= BitsPerWord) begin
      done_byte = shift_acc;
      shift_acc = '0;
      shift_cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Random interval of the requested class under the current thresholds; a long one when no short interval exists.
  function automatic logic [TimeWidth-1:0] draw_interval(input bit want_short);
    logic [TimeWidth-1:0] lo;
    longint unsigned      top;
    if (want_short && thr_min < thr_max) begin
      return $urandom_range(thr_max - 1, thr_min);
    end
    lo  = (thr_max > thr_min) ? thr_max : thr_min;
    top = longint'(lo) + longint'(lo / 2) + 3;
    if (top > 64'hFFFF_FFFF) begin
      top = 64'hFFFF_FFFF;
    end
    return $urandom_range(top[31:0], lo);
  endfunction

  task automatic send_at(input logic [TimeWidth-1:0] t, input logic lvl,
                         input logic has_exp, input logic [DataWidth-1:0] exp_byte);
    logic                 made;
    logic [DataWidth-1:0] predicted;
    while (!steady && $urandom_range(99, 0) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    edge_time  <= t;
    line_level <= lvl;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    now_us = t;
    made   = decode_edge(t, lvl, predicted);
    if (has_exp) begin
      if (!made || predicted !== exp_byte) begin
        report_mismatch($sformatf("typed byte %h differs from prediction %h (made %0b)",
                                  exp_byte, predicted, made));
      end
      byte_q.push_back(exp_byte);
    end else if (made) begin
      byte_q.push_back(predicted);
    end
  endtask

  task automatic send_after(input logic [TimeWidth-1:0] interval, input logic lvl);
    send_at(now_us + interval, lvl, 1'b0, '0);
  endtask

  // Stops offering edges and lets the block drain before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    wait (byte_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgShortMin: thr_min = val;
      CfgShortMax: thr_max = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly well-formed Manchester bit streams, with glitches and arbitrary edges mixed in.
  task automatic run_setting(input int n);
    int                   counted;
    int                   roll;
    logic [TimeWidth-1:0] iv;
    logic                 b;
    counted = 0;
    while (counted < n) begin
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
        send_after($urandom_range(thr_min - 1, 0), 1'($urandom_range(1, 0)));
      end else if (roll < 14) begin
        iv = $urandom();
        send_after(iv, 1'($urandom_range(1, 0)));
        if (iv >= thr_min) begin
          counted++;
        end
      end else begin
        b = 1'($urandom_range(1, 0));
        if (b == prev_bit) begin
          send_after(draw_interval(1'b1), !b);
          send_after(draw_interval(1'b1), b);
          counted += 2;
        end else begin
          send_after(draw_interval(1'b0), b);
          counted++;
        end
        prev_bit = b;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99, 0) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        report_mismatch($sformatf("byte %h with no expectation", data_byte));
      end else begin
        if (data_byte !== byte_q[0]) begin
          report_mismatch($sformatf("data_byte %h, expected %h", data_byte, byte_q[0]));
        end
        void'(byte_q.pop_front());
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowCfg) begin
        settle();
        write_reg(DirectedRows[i].idx, DirectedRows[i].value);
      end else begin
        send_at(DirectedRows[i].value, DirectedRows[i].lvl,
                DirectedRows[i].has_exp, DirectedRows[i].exp_byte);
      end
    end

    for (int s = 0; s < NumSettings; s++) begin
      settle();
      write_reg(CfgShortMin, SettingMin[s]);
      write_reg(CfgShortMax, SettingMax[s]);
      steady = (s == 2);
      if (s == 0) begin
        hold_off_req = 1'b1;
      end
      run_setting(ItemsPerSetting);
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    wait (byte_q.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mted_pkg.sv
sv/mted_timer.sv
sv/mted_fsm.sv
sv/manchester_edge_timing_decoder_unit.sv
sim/testbench.sv
